// ----- hdl/crce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_pkg
// Types, codes and frame tables shared by the card reader command engine.
// ----------------------------------------------------------------------------
package crce_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  command;
    logic [31:0] amount;
    logic [7:0]  sim_position;
    logic [7:0]  rx_byte;
  } crce_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  tag;
    logic [55:0] value;
    logic        last;
  } crce_out_t;

  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_POLL = 2'd2;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_REP = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_FAILED  = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_PIN     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RETRY   = 2'd2;

  localparam logic [3:0] CMD_FIND     = 4'd0;
  localparam logic [3:0] CMD_PRETREAT = 4'd1;
  localparam logic [3:0] CMD_START    = 4'd2;
  localparam logic [3:0] CMD_STOP     = 4'd3;
  localparam logic [3:0] CMD_ADD      = 4'd4;
  localparam logic [3:0] CMD_EJECT    = 4'd5;
  localparam logic [3:0] CMD_SIM      = 4'd6;
  localparam logic [3:0] CMD_ANT_OFF  = 4'd7;
  localparam logic [3:0] CMD_CHECK    = 4'd8;

  localparam logic [7:0] STX_BYTE     = 8'h02;
  localparam logic [7:0] ETX_BYTE     = 8'h03;
  localparam logic [7:0] STATUS_OK    = 8'h59;
  localparam logic [7:0] STATUS_EJECT = 8'h30;
  localparam logic [7:0] FLAG_YES     = 8'h30;
  localparam logic [5:0] STATUS_POS   = 6'd5;
  localparam logic [5:0] FIELD_POS    = 6'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEND, ST_RECV, ST_TX, ST_CL_RD, ST_CL_ST, ST_CL_DEC,
    ST_REP0, ST_F_RD, ST_F_SH, ST_F_EM, ST_END
  } crce_state_e;

  typedef enum logic [1:0] {EM_TX, EM_ST, EM_FIELD, EM_END} emit_sel_e;

  typedef enum logic [1:0] {FM_RAW, FM_ACC30, FM_ST30, FM_ST59} fmode_e;

  typedef struct packed {
    logic [4:0] tag;
    logic [2:0] cnt;
    fmode_e     mode;
  } field_t;

  typedef struct packed {
    logic       latch_req;
    logic       rx_store;
    logic       clr_mark;
    logic       poll_inc;
    logic       tx_start;
    logic       close_clr;
    logic       retry_inc;
    logic       chain;
    logic       st_load;
    logic       acc_clr;
    logic       acc_shift;
    logic       rd_en;
    logic [5:0] rd_addr;
    logic       emit;
    emit_sel_e  emit_sel;
    logic [4:0] tx_idx;
    logic       tx_last;
    logic [4:0] tag;
    fmode_e     mode;
    logic [1:0] end_code;
    logic       last;
  } crce_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       mark;
    logic       rx_nz;
    logic       poll_expired;
    logic       retry_ok;
    logic       frame_ok;
    logic       can_emit;
  } crce_stat_t;

  function automatic logic [4:0] pay_len(input logic [3:0] c);
    logic [4:0] p;
    case (c)
      CMD_PRETREAT: p = 5'd10;
      CMD_START:    p = 5'd7;
      CMD_STOP:     p = 5'd11;
      CMD_SIM:      p = 5'd1;
      default:      p = 5'd0;
    endcase
    return p;
  endfunction

  function automatic logic [4:0] frame_len(input logic [3:0] c);
    return pay_len(c) + 5'd7;
  endfunction

  function automatic logic [7:0] cls_byte(input logic [3:0] c);
    logic [7:0] b;
    case (c)
      CMD_EJECT, CMD_SIM: b = 8'h32;
      CMD_ANT_OFF:        b = 8'h34;
      default:            b = 8'h51;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] op_byte(input logic [3:0] c);
    logic [7:0] b;
    case (c)
      CMD_FIND:     b = 8'h37;
      CMD_PRETREAT: b = 8'h36;
      CMD_START:    b = 8'h30;
      CMD_STOP:     b = 8'h34;
      CMD_ADD:      b = 8'h35;
      CMD_EJECT:    b = 8'h40;
      CMD_SIM:      b = 8'h41;
      CMD_ANT_OFF:  b = 8'h42;
      default:      b = 8'h56;
    endcase
    return b;
  endfunction

  // Every byte of the request frame except the trailing check byte.
  function automatic logic [7:0] frame_byte(input logic [3:0] c, input logic [4:0] i,
                                            input logic [31:0] amt, input logic [23:0] pin,
                                            input logic [7:0] pos);
    logic [4:0] p;
    logic [4:0] j;
    logic [7:0] b;
    p = pay_len(c);
    j = i - 5'd5;
    b = 8'h00;
    if (i == 5'd0) begin
      b = STX_BYTE;
    end else if (i == 5'd1) begin
      b = 8'h00;
    end else if (i == 5'd2) begin
      b = {3'd0, p} + 8'd2;
    end else if (i == 5'd3) begin
      b = cls_byte(c);
    end else if (i == 5'd4) begin
      b = op_byte(c);
    end else if (i == p + 5'd5) begin
      b = ETX_BYTE;
    end else begin
      case (c)
        CMD_PRETREAT: begin
          if (j == 5'd7) b = pin[23:16];
          else if (j == 5'd8) b = pin[15:8];
          else if (j == 5'd9) b = pin[7:0];
        end
        CMD_STOP: begin
          if (j == 5'd0) b = amt[31:24];
          else if (j == 5'd1) b = amt[23:16];
          else if (j == 5'd2) b = amt[15:8];
          else if (j == 5'd3) b = amt[7:0];
        end
        CMD_SIM: b = pos;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  function automatic logic [5:0] resp_len(input logic [3:0] c);
    logic [5:0] n;
    case (c)
      CMD_FIND:           n = 6'd10;
      CMD_PRETREAT:       n = 6'd28;
      CMD_START, CMD_STOP: n = 6'd12;
      CMD_ADD:            n = 6'd50;
      CMD_CHECK:          n = 6'd17;
      default:            n = 6'd8;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] field_num(input logic [3:0] c);
    logic [3:0] n;
    case (c)
      CMD_FIND:     n = 4'd2;
      CMD_PRETREAT: n = 4'd7;
      CMD_ADD:      n = 4'd11;
      default:      n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic field_t fe(input logic [4:0] t, input logic [2:0] n, input fmode_e m);
    field_t f;
    f.tag  = t;
    f.cnt  = n;
    f.mode = m;
    return f;
  endfunction

  // Fields reported after the status byte, read in order from byte six on.
  function automatic field_t field_get(input logic [3:0] c, input logic [3:0] k);
    field_t f;
    f = fe(5'd3, 3'd1, FM_RAW);
    case (c)
      CMD_FIND: f = (k == 4'd0) ? fe(5'd1, 3'd1, FM_ACC30) : fe(5'd2, 3'd1, FM_ACC30);
      CMD_PRETREAT: begin
        case (k)
          4'd0:    f = fe(5'd3, 3'd1, FM_RAW);
          4'd1:    f = fe(5'd4, 3'd1, FM_RAW);
          4'd2:    f = fe(5'd5, 3'd4, FM_RAW);
          4'd3:    f = fe(5'd6, 3'd4, FM_RAW);
          4'd4:    f = fe(5'd7, 3'd4, FM_RAW);
          4'd5:    f = fe(5'd8, 3'd2, FM_RAW);
          default: f = fe(5'd9, 3'd2, FM_RAW);
        endcase
      end
      CMD_START, CMD_STOP: f = fe(5'd7, 3'd4, FM_RAW);
      CMD_ADD: begin
        case (k)
          4'd0:    f = fe(5'd5, 3'd4, FM_RAW);
          4'd1:    f = fe(5'd6, 3'd4, FM_RAW);
          4'd2:    f = fe(5'd10, 3'd4, FM_RAW);
          4'd3:    f = fe(5'd11, 3'd2, FM_RAW);
          4'd4:    f = fe(5'd7, 3'd4, FM_RAW);
          4'd5:    f = fe(5'd12, 3'd4, FM_RAW);
          4'd6:    f = fe(5'd13, 3'd1, FM_RAW);
          4'd7:    f = fe(5'd14, 3'd6, FM_RAW);
          4'd8:    f = fe(5'd15, 3'd7, FM_RAW);
          4'd9:    f = fe(5'd16, 3'd2, FM_RAW);
          default: f = fe(5'd17, 3'd4, FM_RAW);
        endcase
      end
      CMD_EJECT:   f = fe(5'd18, 3'd0, FM_ST30);
      CMD_SIM:     f = fe(5'd19, 3'd0, FM_ST59);
      CMD_ANT_OFF: f = fe(5'd20, 3'd0, FM_ST59);
      default:     f = fe(5'd3, 3'd1, FM_RAW);
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/crce_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_ctrl
// Exchange sequencer: takes requests, bytes and polls, and steps the datapath
// through frame transmission, response readout and field reporting.
// ----------------------------------------------------------------------------
module crce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           req_type_i,
  output logic                 in_ready_o,
  input  crce_pkg::crce_stat_t stat_i,
  output crce_pkg::crce_cmd_t  cmd_o
);
  import crce_pkg::*;

  crce_state_e state_q, state_d;
  logic [4:0]  tx_idx_q, tx_idx_d;
  logic [3:0]  fld_q, fld_d;
  logic [2:0]  byte_q, byte_d;
  logic [5:0]  ptr_q, ptr_d;
  logic [1:0]  end_q, end_d;

  logic   fire;
  logic   is_find;
  logic   fld_last;
  logic   retryable;
  field_t fi, fi_next;

  assign in_ready_o = (state_q == ST_IDLE) || (state_q == ST_SEND) || (state_q == ST_RECV);
  assign fire       = in_valid_i && in_ready_o;
  assign is_find    = (stat_i.cmd == CMD_FIND);
  assign fi         = field_get(stat_i.cmd, fld_q);
  assign fi_next    = field_get(stat_i.cmd, fld_q + 4'd1);
  assign fld_last   = (fld_q == field_num(stat_i.cmd) - 4'd1);
  assign retryable  = (stat_i.cmd >= CMD_START) && (stat_i.cmd <= CMD_ANT_OFF);

  always_comb begin
    state_d  = state_q;
    tx_idx_d = tx_idx_q;
    fld_d    = fld_q;
    byte_d   = byte_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire && req_type_i == REQ_CMD) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (fire && req_type_i == REQ_POLL) begin
          state_d  = ST_TX;
          tx_idx_d = 5'd0;
        end
      end
      ST_RECV: begin
        if (fire && req_type_i == REQ_CMD) begin
          state_d = ST_SEND;
        end else if (fire && req_type_i == REQ_POLL && !stat_i.mark) begin
          if (stat_i.rx_nz) begin
            state_d = ST_CL_RD;
          end else if (stat_i.poll_expired) begin
            state_d = ST_END;
            end_d   = OUT_TIMEOUT;
          end
        end
      end
      ST_TX: begin
        if (stat_i.can_emit) begin
          tx_idx_d = tx_idx_q + 5'd1;
          if (cmd_o.tx_last) state_d = ST_RECV;
        end
      end
      ST_CL_RD: state_d = ST_CL_ST;
      ST_CL_ST: state_d = ST_CL_DEC;
      ST_CL_DEC: begin
        if (stat_i.frame_ok) begin
          state_d = ST_REP0;
        end else if (retryable && stat_i.retry_ok) begin
          state_d = ST_SEND;
        end else begin
          state_d = ST_END;
          end_d   = OUT_FAILED;
        end
      end
      ST_REP0: begin
        if (stat_i.can_emit) begin
          fld_d   = 4'd0;
          ptr_d   = FIELD_POS;
          byte_d  = 3'd0;
          state_d = (fi.cnt != 3'd0) ? ST_F_RD : ST_F_EM;
        end
      end
      ST_F_RD: begin
        ptr_d   = ptr_q + 6'd1;
        byte_d  = byte_q + 3'd1;
        state_d = ST_F_SH;
      end
      ST_F_SH: state_d = (byte_q == fi.cnt) ? ST_F_EM : ST_F_RD;
      ST_F_EM: begin
        if (stat_i.can_emit) begin
          byte_d = 3'd0;
          fld_d  = fld_q + 4'd1;
          if (fld_last) begin
            if (is_find) begin
              state_d = ST_SEND;
            end else begin
              state_d = ST_END;
              end_d   = OUT_OK;
            end
          end else begin
            state_d = (fi_next.cnt != 3'd0) ? ST_F_RD : ST_F_EM;
          end
        end
      end
      ST_END: begin
        if (stat_i.can_emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.emit_sel = EM_TX;
    cmd_o.mode     = fi.mode;
    cmd_o.tag      = fi.tag;
    cmd_o.tx_idx   = tx_idx_q;
    cmd_o.tx_last  = (tx_idx_q == frame_len(stat_i.cmd) - 5'd1);
    cmd_o.end_code = end_q;
    cmd_o.rd_addr  = ptr_q;
    cmd_o.latch_req = fire && (req_type_i == REQ_CMD);
    unique case (state_q)
      ST_SEND: begin
        cmd_o.tx_start = fire && (req_type_i == REQ_POLL);
      end
      ST_RECV: begin
        if (fire && req_type_i == REQ_BYTE) cmd_o.rx_store = 1'b1;
        if (fire && req_type_i == REQ_POLL) begin
          if (stat_i.mark) begin
            cmd_o.clr_mark = 1'b1;
          end else if (!stat_i.rx_nz) begin
            if (stat_i.poll_expired) cmd_o.close_clr = 1'b1;
            else cmd_o.poll_inc = 1'b1;
          end
        end
      end
      ST_TX: begin
        cmd_o.emit     = stat_i.can_emit;
        cmd_o.emit_sel = EM_TX;
        cmd_o.last     = cmd_o.tx_last;
      end
      ST_CL_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = STATUS_POS;
      end
      ST_CL_ST: cmd_o.st_load = 1'b1;
      ST_CL_DEC: begin
        cmd_o.close_clr = 1'b1;
        cmd_o.retry_inc = !stat_i.frame_ok && retryable && stat_i.retry_ok;
      end
      ST_REP0: begin
        cmd_o.emit     = stat_i.can_emit;
        cmd_o.emit_sel = EM_ST;
        cmd_o.acc_clr  = stat_i.can_emit;
      end
      ST_F_RD: cmd_o.rd_en = 1'b1;
      ST_F_SH: cmd_o.acc_shift = 1'b1;
      ST_F_EM: begin
        cmd_o.emit     = stat_i.can_emit;
        cmd_o.emit_sel = EM_FIELD;
        cmd_o.acc_clr  = stat_i.can_emit;
        cmd_o.last     = is_find && fld_last;
        cmd_o.chain    = stat_i.can_emit && is_find && fld_last;
      end
      ST_END: begin
        cmd_o.emit     = stat_i.can_emit;
        cmd_o.emit_sel = EM_END;
        cmd_o.last     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tx_idx_q <= '0;
      fld_q    <= '0;
      byte_q   <= '0;
      ptr_q    <= '0;
      end_q    <= OUT_OK;
    end else begin
      state_q  <= state_d;
      tx_idx_q <= tx_idx_d;
      fld_q    <= fld_d;
      byte_q   <= byte_d;
      ptr_q    <= ptr_d;
      end_q    <= end_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.can_emit) else $error("word emitted into a full output register");
  a_one_input_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.latch_req, cmd_o.rx_store, cmd_o.clr_mark, cmd_o.poll_inc,
              cmd_o.tx_start})) else $error("more than one input action at once");
  a_tx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TX && cmd_o.emit && cmd_o.tx_last) |=> state_q == ST_RECV)
    else $error("frame transmission did not hand over to receive");
  a_close_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CL_RD) |=> ##1 state_q == ST_CL_DEC)
    else $error("close sequence broken");
`endif

endmodule

// ----- hdl/crce_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crce_dp
// Datapath: configuration, held request, receive buffer memory, check sums,
// field assembly and the output register.
// ----------------------------------------------------------------------------
module crce_dp #(
  parameter int RX_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [23:0]          cfg_data_i,
  input  crce_pkg::crce_in_t   in_data_i,
  input  crce_pkg::crce_cmd_t  cmd_i,
  output crce_pkg::crce_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output crce_pkg::crce_out_t  out_data_o
);
  import crce_pkg::*;

  localparam int AW = $clog2(RX_DEPTH);
  localparam int CW = $clog2(RX_DEPTH + 1);

  logic [23:0]   pin_q;
  logic [7:0]    tmo_q, rlim_q;
  logic [3:0]    cmd_q;
  logic [31:0]   amt_q;
  logic [7:0]    pos_q;
  logic [CW-1:0] rx_cnt_q;
  logic          mark_q;
  logic [7:0]    xor_q, poll_q, retry_q, tx_xor_q, st_q, rd_q;
  logic [55:0]   acc_q;
  logic [7:0]    mem [RX_DEPTH];
  logic          out_valid_q;
  crce_out_t     out_q;

  logic          can_emit;
  logic          reader;
  logic [7:0]    tx_byte;
  crce_out_t     word;

  assign can_emit = !out_valid_q || out_ready_i;
  assign reader   = (cmd_q <= CMD_ADD) || (cmd_q == CMD_CHECK);
  assign tx_byte  = cmd_i.tx_last ? tx_xor_q
                                  : frame_byte(cmd_q, cmd_i.tx_idx, amt_q, pin_q, pos_q);

  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.mark         = mark_q;
    stat_o.rx_nz        = (rx_cnt_q != '0);
    stat_o.poll_expired = (poll_q >= tmo_q);
    stat_o.retry_ok     = (retry_q < rlim_q);
    stat_o.frame_ok     = (rx_cnt_q == CW'(resp_len(cmd_q))) && (xor_q == 8'h00) &&
                          (!reader || st_q == STATUS_OK);
    stat_o.can_emit     = can_emit;
  end

  always_comb begin
    word      = '0;
    word.last = cmd_i.last;
    case (cmd_i.emit_sel)
      EM_TX: begin
        word.kind  = KIND_TX;
        word.value = {48'd0, tx_byte};
      end
      EM_ST: begin
        word.kind  = KIND_REP;
        word.value = {48'd0, st_q};
      end
      EM_FIELD: begin
        word.kind = KIND_REP;
        word.tag  = cmd_i.tag;
        case (cmd_i.mode)
          FM_RAW:   word.value = acc_q;
          FM_ACC30: word.value = {55'd0, acc_q[7:0] == FLAG_YES};
          FM_ST30:  word.value = {55'd0, st_q == STATUS_EJECT};
          default:  word.value = {55'd0, st_q == STATUS_OK};
        endcase
      end
      default: begin
        word.kind  = KIND_END;
        word.value = {54'd0, cmd_i.end_code};
      end
    endcase
  end

  // Receive memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_store && rx_cnt_q < CW'(RX_DEPTH)) begin
      mem[rx_cnt_q[AW-1:0]] <= in_data_i.rx_byte;
    end
    if (cmd_i.rd_en) rd_q <= mem[AW'(cmd_i.rd_addr)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.st_load) st_q <= rd_q;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_shift) acc_q <= {acc_q[47:0], rd_q};
    if (cmd_i.emit) out_q <= word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q       <= '0;
      tmo_q       <= 8'd100;
      rlim_q      <= 8'd3;
      cmd_q       <= '0;
      amt_q       <= '0;
      pos_q       <= '0;
      rx_cnt_q    <= '0;
      mark_q      <= 1'b0;
      xor_q       <= '0;
      poll_q      <= '0;
      retry_q     <= '0;
      tx_xor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PIN:     pin_q  <= cfg_data_i;
          REG_TIMEOUT: tmo_q  <= cfg_data_i[7:0];
          REG_RETRY:   rlim_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.latch_req) begin
        cmd_q    <= {1'b0, in_data_i.command};
        amt_q    <= in_data_i.amount;
        pos_q    <= in_data_i.sim_position;
        retry_q  <= '0;
        poll_q   <= '0;
        rx_cnt_q <= '0;
        xor_q    <= '0;
        mark_q   <= 1'b0;
      end
      if (cmd_i.tx_start) begin
        rx_cnt_q <= '0;
        xor_q    <= '0;
        mark_q   <= 1'b0;
        poll_q   <= '0;
        tx_xor_q <= '0;
      end
      if (cmd_i.emit && cmd_i.emit_sel == EM_TX) tx_xor_q <= tx_xor_q ^ tx_byte;
      if (cmd_i.rx_store) begin
        mark_q <= 1'b1;
        if (rx_cnt_q < CW'(RX_DEPTH)) begin
          rx_cnt_q <= rx_cnt_q + CW'(1);
          xor_q    <= xor_q ^ in_data_i.rx_byte;
        end
      end
      if (cmd_i.clr_mark) mark_q <= 1'b0;
      if (cmd_i.poll_inc) poll_q <= poll_q + 8'd1;
      if (cmd_i.close_clr) begin
        rx_cnt_q <= '0;
        xor_q    <= '0;
        poll_q   <= '0;
      end
      if (cmd_i.retry_inc) retry_q <= retry_q + 8'd1;
      if (cmd_i.chain) begin
        cmd_q   <= CMD_CHECK;
        retry_q <= '0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/card_reader_command_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_reader_command_engine_unit
// Command and response engine for a serial card reader.
// ----------------------------------------------------------------------------
// Requests, bytes and polls are taken in the idle, send and receive states.
// A sending poll sends a 7 to 18 byte frame, one word a cycle while not stalled.
// A closing poll reads the status byte through CL_RD, CL_ST and CL_DEC and, if
// the frame checks out, emits the status word; each report field then reads its
// response bytes through the registered receive buffer port, a read and a shift
// state per byte, and emits its word; an end word follows, or a find reply chains
// into a check command. Emits wait on output stalls. Reset is asynchronous,
// active low, and leaves the engine idle with default registers; no clearing pass.
module card_reader_command_engine_unit #(
  parameter int RX_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crce_pkg::crce_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crce_pkg::crce_out_t out_data_o
);
  import crce_pkg::*;

  crce_cmd_t  cmd;
  crce_stat_t stat;

  crce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crce_dp #(
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
